// ----- rtl/core/set_assoc_lru_cache_sim_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the set-associative LRU cache simulator
// Each macro clocks on i_clk and is disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_LRU_CACHE_SIM_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_SIM_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define SAC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SAC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/sac_pkg.sv -----
// ----------------------------------------------------------------------------
// sac_pkg
// Shared types, constants and width helpers of the LRU cache simulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sac_pkg;

    // Default build sizes.
    localparam int SAC_MAX_SET_BITS = 8;
    localparam int SAC_WAYS         = 8;
    localparam int SAC_ADDR_WIDTH   = 64;

    // Stream and configuration port widths.
    localparam int SAC_IN_TDATA_W  = 64;
    localparam int SAC_CNT_W       = 32;
    localparam int SAC_OUT_PAD_W   = 6;
    localparam int SAC_OUT_TDATA_W = 2 + 3 * SAC_CNT_W + SAC_OUT_PAD_W;
    localparam int SAC_CFG_IDX_W   = 2;
    localparam int SAC_CFG_DATA_W  = 6;

    // Configuration register indexes.
    localparam logic [SAC_CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [SAC_CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
    localparam logic [SAC_CFG_IDX_W-1:0] CFG_ASSOC      = 2'd2;

    // Configuration reset values.
    localparam logic [3:0] CFG_RST_SET_BITS   = 4'd4;
    localparam logic [5:0] CFG_RST_BLOCK_BITS = 6'd4;
    localparam logic [3:0] CFG_RST_ASSOC      = 4'd1;

    typedef enum logic [1:0] {
        OUT_HIT   = 2'd0,
        OUT_FILL  = 2'd1,
        OUT_EVICT = 2'd2
    } t_outcome;

    typedef enum logic [1:0] {
        ST_CLEAR  = 2'd0,
        ST_IDLE   = 2'd1,
        ST_LOOKUP = 2'd2
    } t_state;

    typedef struct packed {
        logic [3:0] set_bits;
        logic [5:0] block_bits;
        logic [3:0] assoc;
    } t_cfg;

    typedef struct packed {
        t_outcome outcome;
        logic     tag_we;
    } t_lookup_res;

    // Bits of one LRU age or way index.
    function automatic int sac_age_w(input int ways);
        return (ways > 1) ? $clog2(ways) : 1;
    endfunction

    // Bits of a fill count, which runs from zero to the way count.
    function automatic int sac_fill_w(input int ways);
        return $clog2(ways + 1);
    endfunction

endpackage

// ----- rtl/core/set_assoc_lru_cache_sim.sv -----
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim
// Set-associative cache hit/miss simulator with LRU replacement.
// Each access reads its set row from the tag and age memories at the address
// transfer, then compares and writes the row back in the lookup state, whose
// result is registered for output; the lookup waits while the output register
// still holds an untaken result. No new address is taken until the lookup
// completes. Reset: the control registers and totals clear, then a pass over
// all 2**MAX_SET_BITS sets (256 by default) empties every set; no address is
// taken until it ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "set_assoc_lru_cache_sim_macros.svh"

module set_assoc_lru_cache_sim #(
    parameter int MAX_SET_BITS = sac_pkg::SAC_MAX_SET_BITS,
    parameter int WAYS         = sac_pkg::SAC_WAYS,
    parameter int ADDR_WIDTH   = sac_pkg::SAC_ADDR_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [63:0] address
    input  logic [sac_pkg::SAC_IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [1:0] outcome, [33:2] hit_count, [65:34] miss_count,
    // [97:66] eviction_count, [103:98] zero
    output logic [sac_pkg::SAC_OUT_TDATA_W-1:0] o_m_axis_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sac_pkg::SAC_CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sac_pkg::SAC_CFG_DATA_W-1:0]  i_cfg_data
);
    import sac_pkg::*;

    localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int NUM_SETS = 1 << MAX_SET_BITS;
    localparam int FILL_W   = sac_fill_w(WAYS);
    localparam int META_W   = FILL_W + WAYS * sac_age_w(WAYS);
    localparam int ROW_W    = WAYS * ADDR_WIDTH;

    t_cfg                  cfg;
    t_state                r_state;
    t_state                n_state;
    logic [SET_W-1:0]      r_clr_idx;
    logic [SET_W-1:0]      n_clr_idx;
    logic [SET_W-1:0]      r_set;
    logic [ADDR_WIDTH-1:0] r_tag;
    logic                  r_out_valid;
    logic                  n_out_valid;
    t_outcome              r_outcome;
    logic [SAC_CNT_W-1:0]  r_hits;
    logic [SAC_CNT_W-1:0]  r_misses;
    logic [SAC_CNT_W-1:0]  r_evicts;

    logic                  s_accept;
    logic                  lookup_done;
    logic                  clearing;
    logic [3:0]            set_bits_eff;
    logic [FILL_W-1:0]     assoc_eff;
    logic [ADDR_WIDTH-1:0] addr_m;
    logic [ADDR_WIDTH-1:0] addr_sh;
    logic [6:0]            tag_shift;
    logic [SET_W-1:0]      set_mask;
    logic [SET_W-1:0]      set_idx;
    logic [ADDR_WIDTH-1:0] tag_val;
    logic [ROW_W-1:0]      tag_row_rd;
    logic [META_W-1:0]     meta_row_rd;
    logic [ROW_W-1:0]      tag_row_wr;
    logic [META_W-1:0]     meta_row_upd;
    t_lookup_res           res;

    sac_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Address split, done in the transfer cycle so the set row can be read.
    assign set_bits_eff = (cfg.set_bits > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS)
                                                            : cfg.set_bits;
    assign addr_m    = i_s_axis_tdata[ADDR_WIDTH-1:0];
    assign addr_sh   = addr_m >> cfg.block_bits;
    assign tag_shift = {1'b0, cfg.block_bits} + {3'b000, set_bits_eff};
    assign set_mask  = ~({SET_W{1'b1}} << set_bits_eff);
    assign set_idx   = addr_sh[SET_W-1:0] & set_mask;
    assign tag_val   = addr_m >> tag_shift;

    always_comb begin
        if (int'(cfg.assoc) > WAYS) begin
            assoc_eff = FILL_W'(WAYS);
        end else if (cfg.assoc == 4'd0) begin
            assoc_eff = FILL_W'(1);
        end else begin
            assoc_eff = FILL_W'(cfg.assoc);
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign clearing        = (r_state == ST_CLEAR);
    // The lookup completes only when the output register can take its result.
    assign lookup_done     = (r_state == ST_LOOKUP) && (!r_out_valid || i_m_axis_tready);

    sac_set_store #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .WAYS         (WAYS),
        .ADDR_WIDTH   (ADDR_WIDTH)
    ) u_store (
        .i_clk      (i_clk),
        .i_rd_en    (s_accept),
        .i_rd_addr  (set_idx),
        .o_tag_row  (tag_row_rd),
        .o_meta_row (meta_row_rd),
        .i_tag_we   (lookup_done && res.tag_we),
        .i_meta_we  (lookup_done || clearing),
        .i_wr_addr  (clearing ? r_clr_idx : r_set),
        .i_tag_row  (tag_row_wr),
        .i_meta_row (clearing ? {META_W{1'b0}} : meta_row_upd)
    );

    sac_way_logic #(
        .WAYS       (WAYS),
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_ways (
        .i_tag_row  (tag_row_rd),
        .i_meta_row (meta_row_rd),
        .i_tag      (r_tag),
        .i_assoc    (assoc_eff),
        .o_res      (res),
        .o_tag_row  (tag_row_wr),
        .o_meta_row (meta_row_upd)
    );

    always_comb begin
        n_state   = r_state;
        n_clr_idx = r_clr_idx;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_idx == SET_W'(NUM_SETS - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr_idx = r_clr_idx + SET_W'(1);
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (lookup_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (lookup_done) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_evicts    <= '0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_out_valid <= n_out_valid;
            if (lookup_done) begin
                if (res.outcome == OUT_HIT) begin
                    if (r_hits != {SAC_CNT_W{1'b1}}) begin
                        r_hits <= r_hits + SAC_CNT_W'(1);
                    end
                end else begin
                    if (r_misses != {SAC_CNT_W{1'b1}}) begin
                        r_misses <= r_misses + SAC_CNT_W'(1);
                    end
                end
                if ((res.outcome == OUT_EVICT) && (r_evicts != {SAC_CNT_W{1'b1}})) begin
                    r_evicts <= r_evicts + SAC_CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_set <= set_idx;
            r_tag <= tag_val;
        end
        if (lookup_done) begin
            r_outcome <= res.outcome;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{SAC_OUT_PAD_W{1'b0}}, r_evicts, r_misses, r_hits, r_outcome};

    `SAC_ASSERT_NEXT(a_accept_to_lookup, s_accept, r_state == ST_LOOKUP,
        "address transfer did not start a lookup")
    `SAC_ASSERT_NEXT(a_blocked_lookup_holds, (r_state == ST_LOOKUP) && !lookup_done,
        (r_state == ST_LOOKUP) && r_out_valid, "blocked lookup lost its place")
    `SAC_ASSERT_NOW(a_evicts_le_misses, 1'b1, r_evicts <= r_misses,
        "eviction total exceeds miss total")
    `SAC_ASSERT_NEXT(a_hits_monotonic, 1'b1, r_hits >= $past(r_hits),
        "hit total decreased")

endmodule

// ----- rtl/core/sac_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// sac_cfg_regs
// Configuration registers: set bits, block offset bits and associativity.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sac_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sac_pkg::SAC_CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sac_pkg::SAC_CFG_DATA_W-1:0]  i_cfg_data,
    output sac_pkg::t_cfg                       o_cfg
);
    import sac_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SET_BITS:   n_cfg.set_bits   = i_cfg_data[3:0];
                CFG_BLOCK_BITS: n_cfg.block_bits = i_cfg_data[5:0];
                CFG_ASSOC:      n_cfg.assoc      = i_cfg_data[3:0];
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.set_bits   <= CFG_RST_SET_BITS;
            r_cfg.block_bits <= CFG_RST_BLOCK_BITS;
            r_cfg.assoc      <= CFG_RST_ASSOC;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ----- rtl/core/sac_set_store.sv -----
// ----------------------------------------------------------------------------
// sac_set_store
// Tag memory and age/fill memory, one row per set, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sac_set_store #(
    parameter int MAX_SET_BITS = sac_pkg::SAC_MAX_SET_BITS,
    parameter int WAYS         = sac_pkg::SAC_WAYS,
    parameter int ADDR_WIDTH   = sac_pkg::SAC_ADDR_WIDTH
) (
    input  logic                                               i_clk,
    input  logic                                               i_rd_en,
    input  logic [((MAX_SET_BITS > 0) ? MAX_SET_BITS : 1)-1:0] i_rd_addr,
    output logic [WAYS*ADDR_WIDTH-1:0]                         o_tag_row,
    output logic [sac_pkg::sac_fill_w(WAYS)+WAYS*sac_pkg::sac_age_w(WAYS)-1:0] o_meta_row,
    input  logic                                               i_tag_we,
    input  logic                                               i_meta_we,
    input  logic [((MAX_SET_BITS > 0) ? MAX_SET_BITS : 1)-1:0] i_wr_addr,
    input  logic [WAYS*ADDR_WIDTH-1:0]                         i_tag_row,
    input  logic [sac_pkg::sac_fill_w(WAYS)+WAYS*sac_pkg::sac_age_w(WAYS)-1:0] i_meta_row
);
    import sac_pkg::*;

    localparam int NUM_SETS = 1 << MAX_SET_BITS;
    localparam int ROW_W    = WAYS * ADDR_WIDTH;
    localparam int META_W   = sac_fill_w(WAYS) + WAYS * sac_age_w(WAYS);

    logic [ROW_W-1:0]  r_tag_mem  [NUM_SETS];
    logic [META_W-1:0] r_meta_mem [NUM_SETS];
    logic [ROW_W-1:0]  r_tag_rd;
    logic [META_W-1:0] r_meta_rd;

    assign o_tag_row  = r_tag_rd;
    assign o_meta_row = r_meta_rd;

    always_ff @(posedge i_clk) begin
        if (i_tag_we) begin
            r_tag_mem[i_wr_addr] <= i_tag_row;
        end
        if (i_rd_en) begin
            r_tag_rd <= r_tag_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_meta_we) begin
            r_meta_mem[i_wr_addr] <= i_meta_row;
        end
        if (i_rd_en) begin
            r_meta_rd <= r_meta_mem[i_rd_addr];
        end
    end

endmodule

// ----- rtl/core/sac_way_logic.sv -----
// ----------------------------------------------------------------------------
// sac_way_logic
// Parallel tag compare over one set, LRU age update and line replacement.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sac_way_logic #(
    parameter int WAYS       = sac_pkg::SAC_WAYS,
    parameter int ADDR_WIDTH = sac_pkg::SAC_ADDR_WIDTH
) (
    input  logic [WAYS*ADDR_WIDTH-1:0]                 i_tag_row,
    input  logic [sac_pkg::sac_fill_w(WAYS)+WAYS*sac_pkg::sac_age_w(WAYS)-1:0] i_meta_row,
    input  logic [ADDR_WIDTH-1:0]                      i_tag,
    input  logic [sac_pkg::sac_fill_w(WAYS)-1:0]       i_assoc,
    output sac_pkg::t_lookup_res                       o_res,
    output logic [WAYS*ADDR_WIDTH-1:0]                 o_tag_row,
    output logic [sac_pkg::sac_fill_w(WAYS)+WAYS*sac_pkg::sac_age_w(WAYS)-1:0] o_meta_row
);
    import sac_pkg::*;

    localparam int AGE_W  = sac_age_w(WAYS);
    localparam int FILL_W = sac_fill_w(WAYS);
    localparam int META_W = FILL_W + WAYS * AGE_W;

    logic [FILL_W-1:0] fill_raw;
    logic [FILL_W-1:0] fill_c;
    logic [AGE_W-1:0]  oldest;
    logic [AGE_W-1:0]  age [WAYS];
    logic [WAYS-1:0]   filled;
    logic              hit;
    logic              vic_found;
    logic [AGE_W-1:0]  hit_way;
    logic [AGE_W-1:0]  vic_way;
    logic [AGE_W-1:0]  hit_age;
    logic [AGE_W-1:0]  tgt_way;
    logic [AGE_W-1:0]  new_age;
    t_outcome          outcome;

    assign fill_raw = i_meta_row[META_W-1 -: FILL_W];
    assign fill_c   = (fill_raw > FILL_W'(WAYS)) ? FILL_W'(WAYS) : fill_raw;
    // Filled ways always carry the distinct ages 0 .. fill-1, so the LRU
    // line is the one whose age equals fill-1.
    assign oldest   = AGE_W'(fill_c - FILL_W'(1));

    always_comb begin
        hit       = 1'b0;
        hit_way   = '0;
        vic_found = 1'b0;
        vic_way   = '0;
        for (int w = 0; w < WAYS; w++) begin
            age[w]    = i_meta_row[w*AGE_W +: AGE_W];
            filled[w] = (FILL_W'(w) < fill_c);
            if (!hit && filled[w] && (i_tag_row[w*ADDR_WIDTH +: ADDR_WIDTH] == i_tag)) begin
                hit     = 1'b1;
                hit_way = AGE_W'(w);
            end
            if (!vic_found && filled[w] && (age[w] == oldest)) begin
                vic_found = 1'b1;
                vic_way   = AGE_W'(w);
            end
        end
    end

    assign hit_age = age[hit_way];

    always_comb begin
        if (hit) begin
            outcome = OUT_HIT;
        end else if (fill_c < i_assoc) begin
            outcome = OUT_FILL;
        end else begin
            outcome = OUT_EVICT;
        end
    end

    assign tgt_way      = (outcome == OUT_FILL) ? AGE_W'(fill_c) : vic_way;
    assign o_res.outcome = outcome;
    assign o_res.tag_we  = (outcome != OUT_HIT);

    always_comb begin
        o_tag_row  = i_tag_row;
        o_meta_row = i_meta_row;
        new_age    = '0;
        for (int w = 0; w < WAYS; w++) begin
            case (outcome)
                OUT_HIT: begin
                    if (AGE_W'(w) == hit_way) begin
                        new_age = '0;
                    end else if (filled[w] && (age[w] < hit_age)) begin
                        new_age = age[w] + AGE_W'(1);
                    end else begin
                        new_age = age[w];
                    end
                end
                OUT_FILL, OUT_EVICT: begin
                    if (AGE_W'(w) == tgt_way) begin
                        new_age = '0;
                    end else if (filled[w]) begin
                        new_age = age[w] + AGE_W'(1);
                    end else begin
                        new_age = age[w];
                    end
                end
                default: new_age = age[w];
            endcase
            o_meta_row[w*AGE_W +: AGE_W] = new_age;
            if ((outcome != OUT_HIT) && (AGE_W'(w) == tgt_way)) begin
                o_tag_row[w*ADDR_WIDTH +: ADDR_WIDTH] = i_tag;
            end
        end
        o_meta_row[META_W-1 -: FILL_W] =
            (outcome == OUT_FILL) ? (fill_c + FILL_W'(1)) : fill_c;
    end

endmodule
